// ----- rtl/spq_pkg.sv -----
// Shared constants and types for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int CAPACITY_DEF      = 32;
  localparam int PRIORITY_BITS_DEF = 8;
  localparam int PAYLOAD_BITS_DEF  = 16;

  // Port field widths.
  localparam int CMD_W   = 2;
  localparam int PRIO_W  = 8;
  localparam int LOAD_W  = 16;
  localparam int COUNT_W = 6;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Per-cycle command broadcast to the cell row.
  typedef struct packed {
    logic insert;
    logic remove;
  } spq_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/spq_cell.sv -----
// One slot of the sorted row: holds an entry and trades it with its neighbors.
`default_nettype none
module spq_cell #(
  parameter int PRIORITY_BITS = 8,
  parameter int PAYLOAD_BITS  = 16
) (
  input  wire                       clk,
  input  wire spq_pkg::spq_ctl_t    ctl,
  input  wire                       occupied,
  input  wire                       left_keep,
  input  wire [PRIORITY_BITS-1:0]   new_prio,
  input  wire [PAYLOAD_BITS-1:0]    new_load,
  input  wire [PRIORITY_BITS-1:0]   left_prio,
  input  wire [PAYLOAD_BITS-1:0]    left_load,
  input  wire [PRIORITY_BITS-1:0]   right_prio,
  input  wire [PAYLOAD_BITS-1:0]    right_load,
  output logic                      keep,
  output logic [PRIORITY_BITS-1:0]  prio,
  output logic [PAYLOAD_BITS-1:0]   load
);
  import spq_pkg::*;

  // Entries of strictly higher severity stay put on insert.
  assign keep = occupied && (prio > new_prio);

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (!keep) begin
        if (left_keep) begin
          prio <= new_prio;
          load <= new_load;
        end else begin
          prio <= left_prio;
          load <= left_load;
        end
      end
    end else if (ctl.remove) begin
      prio <= right_prio;
      load <= right_load;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sorted_priority_queue_core.sv -----
// A result word is registered: it appears in the cycle after its command word is accepted.
// One command per cycle while the result word is not stalled; every slot of the cell row
// updates in parallel, so insert, remove and clear each complete when accepted.
// Reset (synchronous, active high) empties the queue and drops any pending
// result; slot contents are not cleared, only the entry count.
`default_nettype none
module sorted_priority_queue_core #(
  parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [spq_pkg::CMD_W-1:0]     cmd,
  input  wire [spq_pkg::PRIO_W-1:0]    priority_req,
  input  wire [spq_pkg::LOAD_W-1:0]    payload,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         ok,
  output logic [spq_pkg::PRIO_W-1:0]   out_priority,
  output logic [spq_pkg::LOAD_W-1:0]   out_payload,
  output logic                         is_empty,
  output logic [spq_pkg::COUNT_W-1:0]  entry_count
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic [PRIORITY_BITS+PRIO_W-1:0] req_wide;
  logic [PAYLOAD_BITS+LOAD_W-1:0]  load_wide;
  logic [PRIORITY_BITS-1:0]        new_prio;
  logic [PAYLOAD_BITS-1:0]         new_load;

  wire [CAPACITY-1:0]      keep;
  wire [PRIORITY_BITS-1:0] cell_prio [CAPACITY];
  wire [PAYLOAD_BITS-1:0]  cell_load [CAPACITY];

  logic [PRIORITY_BITS+PRIO_W-1:0] head_prio_wide;
  logic [PAYLOAD_BITS+LOAD_W-1:0]  head_load_wide;
  logic [CNT_W+COUNT_W-1:0]        count_wide;

  logic     accept;
  logic     full;
  logic     nonempty;
  logic     ok_next;
  logic     take_head;
  spq_ctl_t ctl;

  assign req_wide  = (PRIORITY_BITS+PRIO_W)'(priority_req);
  assign load_wide = (PAYLOAD_BITS+LOAD_W)'(payload);
  assign new_prio  = req_wide[PRIORITY_BITS-1:0];
  assign new_load  = load_wide[PAYLOAD_BITS-1:0];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(CAPACITY));
  assign nonempty = (count != '0);

  always_comb begin
    ctl        = '0;
    ok_next    = 1'b0;
    take_head  = 1'b0;
    count_next = count;
    case (cmd)
      CMD_INSERT: begin
        ok_next    = !full;
        ctl.insert = accept && !full;
        if (!full) count_next = count + 1'b1;
      end
      CMD_REMOVE: begin
        ok_next    = nonempty;
        take_head  = nonempty;
        ctl.remove = accept && nonempty;
        if (nonempty) count_next = count - 1'b1;
      end
      CMD_CLEAR: begin
        ok_next    = nonempty;
        count_next = '0;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     occ;
      logic                     lkeep;
      logic [PRIORITY_BITS-1:0] lprio;
      logic [PAYLOAD_BITS-1:0]  lload;
      logic [PRIORITY_BITS-1:0] rprio;
      logic [PAYLOAD_BITS-1:0]  rload;

      assign occ = (CNT_W'(i) < count);

      if (i == 0) begin : g_first
        assign lkeep = 1'b1;
        assign lprio = new_prio;
        assign lload = new_load;
      end else begin : g_mid
        assign lkeep = keep[i-1];
        assign lprio = cell_prio[i-1];
        assign lload = cell_load[i-1];
      end

      // Last slot holds on remove.
      if (i == CAPACITY - 1) begin : g_last
        assign rprio = cell_prio[i];
        assign rload = cell_load[i];
      end else begin : g_inner
        assign rprio = cell_prio[i+1];
        assign rload = cell_load[i+1];
      end

      spq_cell #(
        .PRIORITY_BITS (PRIORITY_BITS),
        .PAYLOAD_BITS  (PAYLOAD_BITS)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occ),
        .left_keep  (lkeep),
        .new_prio   (new_prio),
        .new_load   (new_load),
        .left_prio  (lprio),
        .left_load  (lload),
        .right_prio (rprio),
        .right_load (rload),
        .keep       (keep[i]),
        .prio       (cell_prio[i]),
        .load       (cell_load[i])
      );
    end
  endgenerate

  assign head_prio_wide = (PRIORITY_BITS+PRIO_W)'(cell_prio[0]);
  assign head_load_wide = (PAYLOAD_BITS+LOAD_W)'(cell_load[0]);
  assign count_wide     = (CNT_W+COUNT_W)'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result word; head is read before the row shifts.
  always_ff @(posedge clk) begin
    if (accept) begin
      ok           <= ok_next;
      out_priority <= take_head ? head_prio_wide[PRIO_W-1:0] : '0;
      out_payload  <= take_head ? head_load_wide[LOAD_W-1:0] : '0;
      is_empty     <= (count_next == '0);
      entry_count  <= count_wide[COUNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/spq_checker.sv -----
// Port-level checks for the sorted priority queue, bound to the top level.
`default_nettype none
module spq_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire                          ok,
  input wire [spq_pkg::PRIO_W-1:0]    out_priority,
  input wire [spq_pkg::LOAD_W-1:0]    out_payload,
  input wire                          is_empty,
  input wire [spq_pkg::COUNT_W-1:0]   entry_count
);
  import spq_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted command produced no result word");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> (out_priority == '0) && (out_payload == '0))
    else $error("failed command returned a nonzero entry");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("command taken while result word is stalled");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry_count) && $stable(ok))
    else $error("stalled result word changed");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
`default_nettype wire

// ----- tb/tb_sorted_priority_queue_core.sv -----
// Testbench for the sorted priority queue: directed and random command words checked against a mirror.
`timescale 1ns / 1ps

typedef struct packed {
  logic                        ok;
  logic [spq_pkg::PRIO_W-1:0]  prio;
  logic [spq_pkg::LOAD_W-1:0]  load;
  logic                        empty;
  logic [spq_pkg::COUNT_W-1:0] count;
} queue_result_t;

// Mirror of the queue contents plus the results still owed by the block.
class queue_mirror;
  logic [spq_pkg::PRIO_W-1:0] slot_prio[spq_pkg::CAPACITY_DEF];
  logic [spq_pkg::LOAD_W-1:0] slot_load[spq_pkg::CAPACITY_DEF];
  int unsigned fill;
  queue_result_t owed_results[$];
  int errors;

  function new();
    fill = 0;
    errors = 0;
  endfunction

  function int pending();
    return owed_results.size();
  endfunction

  function void note_command(logic [spq_pkg::CMD_W-1:0] op,
                             logic [spq_pkg::PRIO_W-1:0] prio,
                             logic [spq_pkg::LOAD_W-1:0] load);
    queue_result_t r;
    int unsigned pos;
    r = '0;
    case (op)
      spq_pkg::CMD_INSERT: begin
        if (fill < spq_pkg::CAPACITY_DEF) begin
          pos = 0;
          // Strictly higher severities stay ahead; equal ones go behind the new entry.
          while (pos < fill && slot_prio[pos] > prio) pos++;
          for (int i = fill; i > pos; i--) begin
            slot_prio[i] = slot_prio[i-1];
            slot_load[i] = slot_load[i-1];
          end
          slot_prio[pos] = prio;
          slot_load[pos] = load;
          fill++;
          r.ok = 1'b1;
        end
      end
      spq_pkg::CMD_REMOVE: begin
        if (fill != 0) begin
          r.ok = 1'b1;
          r.prio = slot_prio[0];
          r.load = slot_load[0];
          for (int i = 1; i < fill; i++) begin
            slot_prio[i-1] = slot_prio[i];
            slot_load[i-1] = slot_load[i];
          end
          fill--;
        end
      end
      spq_pkg::CMD_CLEAR: begin
        r.ok = (fill != 0);
        fill = 0;
      end
      default: r.ok = 1'b0;
    endcase
    r.empty = (fill == 0);
    r.count = fill[spq_pkg::COUNT_W-1:0];
    owed_results.push_back(r);
  endfunction

  function void compare_field(string what, logic [spq_pkg::LOAD_W-1:0] want,
                              logic [spq_pkg::LOAD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  function void check_result(queue_result_t got);
    queue_result_t want;
    if (owed_results.size() == 0) begin
      $display("%0t: unexpected result word, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = owed_results.pop_front();
    compare_field("ok", spq_pkg::LOAD_W'(want.ok), spq_pkg::LOAD_W'(got.ok));
    compare_field("out_priority", spq_pkg::LOAD_W'(want.prio), spq_pkg::LOAD_W'(got.prio));
    compare_field("out_payload", want.load, got.load);
    compare_field("is_empty", spq_pkg::LOAD_W'(want.empty), spq_pkg::LOAD_W'(got.empty));
    compare_field("entry_count", spq_pkg::LOAD_W'(want.count), spq_pkg::LOAD_W'(got.count));
  endfunction
endclass

module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1750;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [CMD_W-1:0] cmd;
  logic [PRIO_W-1:0] priority_req;
  logic [LOAD_W-1:0] payload;
  logic out_valid;
  logic out_ready;
  logic ok;
  logic [PRIO_W-1:0] out_priority;
  logic [LOAD_W-1:0] out_payload;
  logic is_empty;
  logic [COUNT_W-1:0] entry_count;

  queue_mirror mirror;
  bit calm;
  int sent;

  sorted_priority_queue_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .priority_req(priority_req), .payload(payload),
    .out_valid(out_valid), .out_ready(out_ready),
    .ok(ok), .out_priority(out_priority), .out_payload(out_payload),
    .is_empty(is_empty), .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_word(input logic [CMD_W-1:0] op, input logic [PRIO_W-1:0] prio,
                           input logic [LOAD_W-1:0] load);
    int gap;
    gap = calm ? 0 : int'($urandom_range(0, 5));
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    cmd = op;
    priority_req = prio;
    payload = load;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror.note_command(op, prio, load);
    sent++;
  endtask

  // Hold off new words until every owed result has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  // Result side: random stalls on out_ready, check each accepted word.
  initial begin
    int stall;
    queue_result_t got;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : int'($urandom_range(0, 5));
      repeat (stall) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = '{ok, out_priority, out_payload, is_empty, entry_count};
      mirror.check_result(got);
    end
  end

  initial begin
    int mode;
    int len;
    int roll;
    bit narrow;
    logic [CMD_W-1:0] op;
    logic [PRIO_W-1:0] prio;

    mirror = new();
    sent = 0;
    calm = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    cmd = CMD_INSERT;
    priority_req = '0;
    payload = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed: empty-queue failures, extremes, ties, unused code, clear.
    send_word(CMD_REMOVE, 8'd0, 16'h0000);
    send_word(CMD_CLEAR, 8'd0, 16'h0000);
    send_word(CMD_UNUSED, 8'hff, 16'hffff);
    send_word(CMD_INSERT, 8'd0, 16'h0000);
    send_word(CMD_INSERT, 8'hff, 16'hffff);
    send_word(CMD_INSERT, 8'h80, 16'h8000);
    send_word(CMD_INSERT, 8'h80, 16'h0001);
    send_word(CMD_INSERT, 8'hff, 16'haaaa);
    send_word(CMD_UNUSED, 8'h00, 16'h0000);
    send_word(CMD_REMOVE, 8'h00, 16'h0000);
    send_word(CMD_REMOVE, 8'hff, 16'hffff);
    send_word(CMD_REMOVE, 8'h00, 16'h0000);
    send_word(CMD_INSERT, 8'h01, 16'h5555);
    send_word(CMD_CLEAR, 8'h00, 16'h0000);
    send_word(CMD_REMOVE, 8'h00, 16'h0000);
    send_word(CMD_INSERT, 8'h7f, 16'h7fff);
    send_word(CMD_REMOVE, 8'h00, 16'h0000);
    hold_until_drained();

    // Random phases: fill-heavy phases hit the full case, drain-heavy ones the empty case.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      mode = int'($urandom_range(0, 2));
      calm = ($urandom_range(0, 3) == 0);
      narrow = 1'($urandom_range(0, 1));
      len = int'($urandom_range(10, 60));
      for (int k = 0; k < len; k++) begin
        roll = int'($urandom_range(0, 99));
        if (roll < 2) op = CMD_CLEAR;
        else if (roll < 3) op = CMD_UNUSED;
        else if (mode == 0) op = (roll < 85) ? CMD_INSERT : CMD_REMOVE;
        else if (mode == 1) op = (roll < 85) ? CMD_REMOVE : CMD_INSERT;
        else op = (roll < 51) ? CMD_INSERT : CMD_REMOVE;
        // Narrow severities force many ties at both ends of the range.
        if (narrow)
          prio = ($urandom_range(0, 1) != 0) ? PRIO_W'($urandom_range(0, 3))
                                              : PRIO_W'($urandom_range(252, 255));
        else
          prio = PRIO_W'($urandom_range(0, 255));
        send_word(op, prio, LOAD_W'($urandom_range(0, 16'hffff)));
      end
      if ($urandom_range(0, 7) == 0) hold_until_drained();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
